[hw/rtl/bdppie_pkg.sv]
// ----------------------------------------------------------------------------
// bdppie_pkg
// Shared widths, constants and types of the probe interval estimator.
// ----------------------------------------------------------------------------
package bdppie_pkg;

    localparam int BYTE_COUNT_BITS = 32;
    localparam int BYTE_W          = (BYTE_COUNT_BITS < 32) ? BYTE_COUNT_BITS : 32;
    localparam int US_W            = 20;
    localparam int PROD_W          = BYTE_W + US_W;
    localparam int ELAPSED_W       = 32;
    localparam int JITTER_W        = 7;
    localparam int DELAY_W         = 15;
    localparam int CEIL_W          = 14;
    localparam int STEP_W          = 8;
    localparam int WIN_W           = 32;
    localparam int COUNT_W         = 2;
    localparam int DIV_CNT_W       = $clog2(PROD_W + 1);

    localparam int S_DATA_W        = 72;
    localparam int M_DATA_W        = 48;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 14;

    localparam logic [US_W-1:0]     US_PER_S   = US_W'(1000000);
    localparam logic [WIN_W-1:0]    BYTE_MASK  = WIN_W'((64'd1 << BYTE_W) - 64'd1);
    localparam logic [WIN_W-1:0]    WIN_RESET  = WIN_W'(65536) & BYTE_MASK;
    localparam logic [DELAY_W-1:0]  DELAY_RESET = DELAY_W'(100);
    localparam logic [DELAY_W-1:0]  DELAY_MAX  = '1;
    localparam logic [JITTER_W-1:0] JITTER_MAX = JITTER_W'(100);
    localparam logic [CEIL_W-1:0]   CEIL_RESET = CEIL_W'(10000);
    localparam logic [STEP_W-1:0]   STEP_RESET = STEP_W'(100);
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
    localparam logic [COUNT_W-1:0]  COUNT_RAMP = COUNT_W'(2);

    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_CEILING = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_STEP     = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[hw/rtl/bdppie_div.sv]
// ----------------------------------------------------------------------------
// bdppie_div
// Restoring divider, one quotient bit per cycle through a shift register.
// ----------------------------------------------------------------------------
module bdppie_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [bdppie_pkg::PROD_W-1:0]    dividend,
    input  logic [bdppie_pkg::ELAPSED_W-1:0] divisor,
    output bdppie_pkg::div_stat_t            stat,
    output logic [bdppie_pkg::PROD_W-1:0]    quotient
);
    import bdppie_pkg::*;

    logic [PROD_W-1:0]    num_reg, num_next;
    logic [ELAPSED_W-1:0] rem_reg, rem_next;
    logic [ELAPSED_W-1:0] dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [ELAPSED_W:0]   trial;
    logic [ELAPSED_W:0]   diff;
    logic                 ge;

    assign trial = {rem_reg, num_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            num_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = DIV_CNT_W'(PROD_W);
        end else if (cnt_reg != '0) begin
            num_next  = {num_reg[PROD_W-2:0], ge};
            rem_next  = ge ? diff[ELAPSED_W-1:0] : trial[ELAPSED_W-1:0];
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = num_reg;

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> cnt_reg == '0)
        else $error("divider done while still iterating");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> stat.busy)
        else $error("divider not busy after start");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.busy && !start) |=> cnt_reg == $past(cnt_reg) - DIV_CNT_W'(1))
        else $error("divider count skipped");

endmodule

[hw/rtl/bdp_probe_interval_estimator.sv]
// ----------------------------------------------------------------------------
// bdp_probe_interval_estimator
// Window estimate and probe delay update from one completed probe per transfer.
// ----------------------------------------------------------------------------
// channel  dir  tdata / payload                               tuser
// s_       in   [31:0] bytes_received [63:32] elapsed_us       -
//               [70:64] jitter_ms
// m_       out  [14:0] next_delay_ms [46:15] window_estimate   [0] estimate_grew
// cfg_     in   cfg_index (0 delay_ceiling_ms, 1 ramp_step_ms), cfg_data
//
// A probe runs from transfer to result through ST_MUL, ST_DIVS, ST_DIV and
// ST_UPD; the bit-serial divider forms bytes * 1e6 / elapsed_us, and zero
// elapsed time skips ST_DIV. A new probe is taken once the previous result
// is loaded into the output register, even if it is still waiting.
// Reset is synchronous and active low; cfg_ready is always high.
// ----------------------------------------------------------------------------
module bdp_probe_interval_estimator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bdppie_pkg::S_DATA_W-1:0]     s_tdata,    // bytes, elapsed, jitter
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bdppie_pkg::M_DATA_W-1:0]     m_tdata,    // next_delay, window
    output logic [0:0]                          m_tuser,    // estimate_grew
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdppie_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bdppie_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bdppie_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIVS,
        ST_DIV,
        ST_UPD
    } state_t;

    state_t               state_reg, state_next;
    logic [BYTE_W-1:0]    bytes_reg, bytes_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [JITTER_W-1:0]  jitter_reg, jitter_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [CEIL_W-1:0]    ceiling_reg, ceiling_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [WIN_W-1:0]     window_reg, window_next;
    logic [PROD_W-1:0]    best_reg, best_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [DELAY_W-1:0]   m_delay_reg, m_delay_next;
    logic [WIN_W-1:0]     m_window_reg, m_window_next;
    logic                 m_grew_reg, m_grew_next;

    div_stat_t            div_stat;
    logic                 div_start;
    logic [PROD_W-1:0]    quotient;

    logic                 s_xfer;
    logic                 out_free;
    logic [JITTER_W-1:0]  jitter_in;
    logic [PROD_W-1:0]    bw;
    logic [WIN_W+1:0]     three_b;
    logic [WIN_W+1:0]     two_w;
    logic                 grow;
    logic [WIN_W:0]       dbl;
    logic [WIN_W:0]       pick;
    logic [WIN_W-1:0]     grown_window;
    logic                 can_ramp;
    logic [COUNT_W-1:0]   count_inc;
    logic [DELAY_W:0]     ramp_sum;
    logic [DELAY_W-1:0]   ramp_delay;
    logic [DELAY_W-1:0]   upd_delay;
    logic [COUNT_W-1:0]   upd_count;

    bdppie_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (elapsed_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign div_start = (state_reg == ST_DIVS) && (elapsed_reg != '0);
    assign jitter_in = (s_tdata[70:64] > JITTER_MAX) ? JITTER_MAX : s_tdata[70:64];

    // update of the estimator state from the finished bandwidth
    always_comb begin
        bw           = (elapsed_reg == '0) ? '0 : quotient;
        three_b      = (WIN_W+2)'(bytes_reg) + (WIN_W+2)'({bytes_reg, 1'b0});
        two_w        = {1'b0, window_reg, 1'b0};
        grow         = (three_b > two_w) && (bw > best_reg);
        dbl          = {window_reg, 1'b0};
        pick         = ((WIN_W+1)'(bytes_reg) > dbl) ? (WIN_W+1)'(bytes_reg) : dbl;
        grown_window = (pick > (WIN_W+1)'(BYTE_MASK)) ? BYTE_MASK : pick[WIN_W-1:0];
        can_ramp     = delay_reg < DELAY_W'(ceiling_reg);
        count_inc    = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + COUNT_W'(1);
        ramp_sum     = (DELAY_W+1)'(delay_reg) + (DELAY_W+1)'(step_reg)
                     + (DELAY_W+1)'(jitter_reg);
        ramp_delay   = (ramp_sum > (DELAY_W+1)'(DELAY_MAX)) ? DELAY_MAX
                                                          : ramp_sum[DELAY_W-1:0];
        upd_delay    = delay_reg;
        upd_count    = count_reg;
        if (grow) begin
            upd_delay = delay_reg >> 1;
        end else if (can_ramp) begin
            upd_count = count_inc;
            if (count_inc >= COUNT_RAMP) begin
                upd_delay = ramp_delay;
            end
        end
        if (upd_delay != delay_reg) begin
            upd_count = '0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        bytes_next    = bytes_reg;
        elapsed_next  = elapsed_reg;
        jitter_next   = jitter_reg;
        prod_next     = prod_reg;
        ceiling_next  = ceiling_reg;
        step_next     = step_reg;
        window_next   = window_reg;
        best_next     = best_reg;
        delay_next    = delay_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_delay_next  = m_delay_reg;
        m_window_next = m_window_reg;
        m_grew_next   = m_grew_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DELAY_CEILING: ceiling_next = cfg_data;
                CFG_RAMP_STEP:     step_next    = cfg_data[STEP_W-1:0];
                default:           ceiling_next = ceiling_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    bytes_next   = s_tdata[BYTE_W-1:0];
                    elapsed_next = s_tdata[63:32];
                    jitter_next  = jitter_in;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(bytes_reg) * PROD_W'(US_PER_S);
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                state_next = (elapsed_reg == '0) ? ST_UPD : ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (out_free) begin
                    if (grow) begin
                        window_next = grown_window;
                        best_next   = bw;
                    end
                    delay_next    = upd_delay;
                    count_next    = upd_count;
                    m_tvalid_next = 1'b1;
                    m_delay_next  = upd_delay;
                    m_window_next = grow ? grown_window : window_reg;
                    m_grew_next   = grow;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ceiling_reg  <= CEIL_RESET;
            step_reg     <= STEP_RESET;
            window_reg   <= WIN_RESET;
            best_reg     <= '0;
            delay_reg    <= DELAY_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ceiling_reg  <= ceiling_next;
            step_reg     <= step_next;
            window_reg   <= window_next;
            best_reg     <= best_next;
            delay_reg    <= delay_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        bytes_reg    <= bytes_next;
        elapsed_reg  <= elapsed_next;
        jitter_reg   <= jitter_next;
        prod_reg     <= prod_next;
        m_delay_reg  <= m_delay_next;
        m_window_reg <= m_window_next;
        m_grew_reg   <= m_grew_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_window_reg, m_delay_reg};
    assign m_tuser  = m_grew_reg;

    a_one_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready)
        else $error("second probe taken while one is in flight");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_grow_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && out_free && grow) |=> window_reg >= $past(window_reg))
        else $error("estimate shrank on growth");

endmodule
